// ===== hw/rtl/ifq_pkg.sv =====
// ifq_pkg: shared constants, register codes and types for the injector fault qualifier.
// No dependencies; imported by every module of the block.
package ifq_pkg;

    localparam int NUM_INJECTORS = 4;
    localparam int SPEED_W       = 16;
    localparam int TIMER_W       = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;

    localparam logic [TIMER_W-1:0] TIMER_MAX      = {TIMER_W{1'b1}};
    localparam logic [TIMER_W-1:0] FAIL_THR_RESET = TIMER_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_THR = 1'b0,
        CFG_FAIL_THR  = 1'b1
    } cfg_idx_t;

    // Per-injector verdict state after the latest tick
    typedef struct packed {
        logic failed;
        logic recent;
        logic sticky;
    } lane_stat_t;

endpackage

// ===== hw/rtl/ifq_cfg.sv =====
// ifq_cfg: configuration registers and the diagnostic enable check.
// Depends on ifq_pkg.
module ifq_cfg
    import ifq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  hw_ok,
    input  logic                  ign_on,
    input  logic [SPEED_W-1:0]    speed,
    output logic                  enabled,
    output logic [TIMER_W-1:0]    fail_thr
);

    logic [SPEED_W-1:0] speed_thr_reg;
    logic [TIMER_W-1:0] fail_thr_reg;
    cfg_idx_t           idx;

    assign idx = cfg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_thr_reg <= '0;
            fail_thr_reg  <= FAIL_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (idx)
                CFG_SPEED_THR: speed_thr_reg <= cfg_wdata[SPEED_W-1:0];
                CFG_FAIL_THR:  fail_thr_reg  <= cfg_wdata[TIMER_W-1:0];
                default:       ;
            endcase
        end
    end

    assign enabled  = hw_ok && ign_on && (speed >= speed_thr_reg);
    assign fail_thr = fail_thr_reg;

endmodule

// ===== hw/rtl/ifq_lane.sv =====
// ifq_lane: one injector's fault timer and latched test verdict.
// Depends on ifq_pkg.
module ifq_lane
    import ifq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               enabled,
    input  logic               fail,
    input  logic [TIMER_W-1:0] fail_thr,
    output lane_stat_t         stat
);

    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               running_reg, running_next;
    logic               failed_reg, failed_next;
    logic               recent_reg, recent_next;
    logic               sticky_reg, sticky_next;
    logic [TIMER_W-1:0] timer_inc;

    always_comb
    begin
        timer_inc    = (running_reg && timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
        failed_next  = failed_reg;
        recent_next  = recent_reg;
        if (enabled && fail)
        begin
            timer_next   = recent_reg ? '0 : timer_inc;
            running_next = 1'b1;
        end
        else
        begin
            timer_next   = '0;
            running_next = 1'b0;
        end
        if (enabled)
        begin
            recent_next = 1'b0;
            if (timer_next > fail_thr)
            begin
                failed_next = 1'b1;
                recent_next = 1'b1;
            end
            else if (!fail)
            begin
                failed_next = 1'b0;
                recent_next = 1'b1;
            end
        end
        sticky_next = sticky_reg || recent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            running_reg <= 1'b0;
            failed_reg  <= 1'b0;
            recent_reg  <= 1'b0;
            sticky_reg  <= 1'b0;
        end
        else if (advance)
        begin
            timer_reg   <= timer_next;
            running_reg <= running_next;
            failed_reg  <= failed_next;
            recent_reg  <= recent_next;
            sticky_reg  <= sticky_next;
        end
    end

    assign stat.failed = failed_reg;
    assign stat.recent = recent_reg;
    assign stat.sticky = sticky_reg;

    // A halted timer always reads zero
    a_halted_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> timer_reg == '0)
        else $error("halted fault timer is not cleared");

endmodule

// ===== hw/rtl/injector_fault_qualifier_unit.sv =====
// injector_fault_qualifier_unit: top level of the injector fault qualifier.
// Depends on ifq_pkg, ifq_cfg and ifq_lane.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  in       | in_valid/in_ready  | hw_enable_ok, ignition_on, engine_speed,
//           |                    | circuit_failed_mask
//  out      | out_valid/out_ready| diag_enabled, fail_now_mask, reset_request,
//           |                    | all_faulted, test_failed_mask, tick_complete_mask,
//           |                    | test_complete_mask
//  cfg      | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// Each request is held in the input register, then one pass of per-injector
// logic writes the result register and the lane state together; one request per
// cycle sustained while out_ready keeps the result register draining.
// The input register takes a new request while the result register still waits on
// out_ready; a full pipeline stalls in_ready only when both stages are held.
// Reset clears all timers, verdicts and valid flags; thresholds return to speed 0 and
// fail time 8.
module injector_fault_qualifier_unit
    import ifq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     hw_enable_ok,
    input  logic                     ignition_on,
    input  logic [SPEED_W-1:0]       engine_speed,
    input  logic [NUM_INJECTORS-1:0] circuit_failed_mask,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     diag_enabled,
    output logic [NUM_INJECTORS-1:0] fail_now_mask,
    output logic                     reset_request,
    output logic                     all_faulted,
    output logic [NUM_INJECTORS-1:0] test_failed_mask,
    output logic [NUM_INJECTORS-1:0] tick_complete_mask,
    output logic [NUM_INJECTORS-1:0] test_complete_mask,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

    // Input register
    logic                     s1_valid_reg;
    logic                     s1_hw_ok_reg;
    logic                     s1_ign_reg;
    logic [SPEED_W-1:0]       s1_speed_reg;
    logic [NUM_INJECTORS-1:0] s1_fail_reg;

    // Result register (lane verdicts are held inside the lanes)
    logic                     out_valid_reg;
    logic                     diag_en_reg;
    logic [NUM_INJECTORS-1:0] fail_now_reg;
    logic                     any_fail_reg;
    logic                     all_fail_reg;

    logic                     advance;
    logic                     enabled;
    logic [TIMER_W-1:0]       fail_thr;
    lane_stat_t               lane_stat [NUM_INJECTORS];

    // Advance the input register into the result stage when the result slot frees up
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless a request moves in
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_hw_ok_reg <= hw_enable_ok;
            s1_ign_reg   <= ignition_on;
            s1_speed_reg <= engine_speed;
            s1_fail_reg  <= circuit_failed_mask;
        end
        if (advance)
        begin
            diag_en_reg  <= enabled;
            fail_now_reg <= s1_fail_reg;
            any_fail_reg <= |s1_fail_reg;
            all_fail_reg <= &s1_fail_reg;
        end
    end

    ifq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .hw_ok    (s1_hw_ok_reg),
        .ign_on   (s1_ign_reg),
        .speed    (s1_speed_reg),
        .enabled  (enabled),
        .fail_thr (fail_thr)
    );

    // One lane per injector; its state updates on the same edge as the result register
    for (genvar i = 0; i < NUM_INJECTORS; i++)
    begin : g_lane
        ifq_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .enabled (enabled),
            .fail    (s1_fail_reg[i]),
            .fail_thr(fail_thr),
            .stat    (lane_stat[i])
        );
        assign test_failed_mask[i]   = lane_stat[i].failed;
        assign tick_complete_mask[i] = lane_stat[i].recent;
        assign test_complete_mask[i] = lane_stat[i].sticky;
    end

    assign out_valid     = out_valid_reg;
    assign diag_enabled  = diag_en_reg;
    assign fail_now_mask = fail_now_reg;
    assign reset_request = any_fail_reg;
    assign all_faulted   = all_fail_reg;

    a_all_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!all_faulted || reset_request))
        else $error("all_faulted without reset_request");

    a_recent_in_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_complete_mask & ~test_complete_mask) == '0)
        else $error("tick completion not absorbed into sticky completion");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("input stage dropped a stalled request");

endmodule
